### hdl/ccp_pkg.sv
`timescale 1ns / 1ps

package ccp_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 10;

	// width of every result field
	localparam int OUT_W = 33;

	// saturation bounds, held one bit wider than the result fields
	localparam logic [OUT_W:0] CEN_POS_MAX = 34'h0_FFFF_FFFF;
	localparam logic [OUT_W:0] CEN_NEG_MAG = 34'h1_0000_0000;
	localparam logic [OUT_W:0] RAD_MAX     = 34'h1_FFFF_FFFF;

endpackage

### hdl/ccp_div_cell.sv
`timescale 1ns / 1ps

// One restoring division step: shift in one numerator bit, trial subtract,
// shift the quotient bit into the low end of the numerator word.
module ccp_div_cell #(
	parameter int NW = 35,
	parameter int DW = 24,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	input  logic [DW-1:0] rem_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [NW-1:0] num_o,
	output logic [DW-1:0] den_o,
	output logic [DW-1:0] rem_o,
	output logic [SW-1:0] side_o
);

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// bring down the next numerator bit and try the divisor
	always_comb begin
		trial = {rem_i, num_i[NW-1]};
		diff  = trial - {1'b0, den_i};
		ge    = trial >= {1'b0, den_i};
	end

	// hold the item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// advance the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_o  <= {num_i[NW-2:0], ge};
			den_o  <= den_i;
			side_o <= side_i;
		end
	end

endmodule

### hdl/ccp_sqrt_cell.sv
`timescale 1ns / 1ps

// One restoring square-root step: bring down two radicand bits and try the
// root so far with a one appended.
module ccp_sqrt_cell #(
	parameter int SB = 32,
	parameter int SW = 22
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*SB-1:0] rad_i,
	input  logic [SB+1:0]   rem_i,
	input  logic [SB-1:0]   root_i,
	input  logic [SW-1:0]   side_i,
	output logic            vld_o,
	output logic [2*SB-1:0] rad_o,
	output logic [SB+1:0]   rem_o,
	output logic [SB-1:0]   root_o,
	output logic [SW-1:0]   side_o
);

	localparam int TB = 2 * SB;

	logic [SB+1:0] trial;
	logic [SB+1:0] test;
	logic [SB+1:0] diff;
	logic          ge;

	// form the trial remainder and the trial root
	always_comb begin
		trial = {rem_i[SB-1:0], rad_i[TB-1:TB-2]};
		test  = {root_i, 2'b01};
		diff  = trial - test;
		ge    = trial >= test;
	end

	// hold the item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// advance remainder, root and radicand
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff : trial;
			root_o <= {root_i[SB-2:0], ge};
			rad_o  <= {rad_i[TB-3:0], 2'b00};
			side_o <= side_i;
		end
	end

endmodule

### hdl/circumcircle_three_points.sv
`timescale 1ns / 1ps

// Circumcircle of three points.
// Input channel: in_valid/in_ready with the six point coordinates ax..cy,
// each COORD_BITS wide, unsigned. A transfer happens when both are high.
// Output channel: out_valid/out_ready with valid_res, center_x, center_y
// and circle_radius. One result leaves for every accepted triple, in order.
// Collinear points give valid_res 0 and all other fields 0.
// The radius path runs through the square-root cell chain of
// 3*COORD_BITS+2 cells followed by the divider chain of 3*COORD_BITS+5 cells.
// Throughput: one triple per cycle while the skid stage is not full; every
// cell takes a new item each cycle unless the pipe is frozen.
// Reset clears all valid flags, including those of the output register and
// the skid stage; the pipe is empty and ready straight after reset.
// When the receiver stalls, the next finished result parks in a skid stage
// and in_ready stays high; only once the skid stage is full does the whole
// pipe freeze and in_ready drop, until the receiver takes a result.
module circumcircle_three_points #(
	parameter int COORD_BITS = ccp_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COORD_BITS-1:0]               ax,
	input  logic [COORD_BITS-1:0]               ay,
	input  logic [COORD_BITS-1:0]               bx,
	input  logic [COORD_BITS-1:0]               by_coord,
	input  logic [COORD_BITS-1:0]               cx,
	input  logic [COORD_BITS-1:0]               cy,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                valid_res,
	output logic signed [ccp_pkg::OUT_W-1:0]    center_x,
	output logic signed [ccp_pkg::OUT_W-1:0]    center_y,
	output logic [ccp_pkg::OUT_W-1:0]           circle_radius
);

	localparam int N   = COORD_BITS;
	localparam int OW  = ccp_pkg::OUT_W;
	localparam int DB  = 2 * N + 3;        // signed determinant
	localparam int AW  = 2 * N + 2;        // determinant magnitude
	localparam int SQB = 2 * N + 1;        // squared norms and side lengths
	localparam int EB  = 3 * N + 4;        // signed centre numerators
	localparam int PB  = 4 * N + 2;        // product of two squared sides
	localparam int L   = 2 * N + 1;        // split point of that product
	localparam int SB  = 3 * N + 2;        // root bits
	localparam int TB  = 2 * SB;           // radicand bits
	localparam int NW  = 3 * N + 5;        // divider numerator
	localparam int DW  = 2 * N + 4;        // divider denominator
	localparam int DLY = SB + 2;           // centre path delay to meet radius
	localparam int EW  = (NW > OW + 1) ? NW : OW + 1;

	logic en;

	// stage 1 registers
	logic                  vld_s1;
	logic [N-1:0]          ax_s1, bx_s1, cx_s1;
	logic signed [N:0]     dy23_s1, dy31_s1, dy12_s1;
	logic signed [N:0]     dx32_s1, dx13_s1, dx21_s1;
	logic [SQB-1:0]        na_s1, nb_s1, nc_s1;
	logic [SQB-1:0]        sa_s1, sb_s1, sc_s1;

	// stage 2 registers
	logic                  vld_s2;
	logic signed [DB-1:0]  det_s2;
	logic signed [EB-1:0]  ne_s2, nf_s2;
	logic [PB-1:0]         pab_s2;
	logic [SQB-1:0]        sc_s2;

	// stage 3 registers
	logic                  vld_s3;
	logic [AW-1:0]         ad_s3;
	logic [NW-1:0]         numx_s3, numy_s3;
	logic [DW-1:0]         denc_s3;
	logic                  negx_s3, negy_s3;
	logic [PB-1:0]         plo_s3, phi_s3;

	// stage 4 registers
	logic                  vld_s4;
	logic [AW-1:0]         ad_s4;
	logic [TB-1:0]         rad_s4;

	// stage 5 registers
	logic                  vld_s5;
	logic [NW-1:0]         numr_s5;
	logic [DW-1:0]         denr_s5;
	logic                  nz_s5;

	// cell chain links
	logic                  cvx_w [0:NW];
	logic [NW-1:0]         cnx_w [0:NW];
	logic [DW-1:0]         cdx_w [0:NW];
	logic [DW-1:0]         crx_w [0:NW];
	logic                  csx_w [0:NW];
	logic                  cvy_w [0:NW];
	logic [NW-1:0]         cny_w [0:NW];
	logic [DW-1:0]         cdy_w [0:NW];
	logic [DW-1:0]         cry_w [0:NW];
	logic                  csy_w [0:NW];
	logic                  rv_w  [0:NW];
	logic [NW-1:0]         rn_w  [0:NW];
	logic [DW-1:0]         rd_w  [0:NW];
	logic [DW-1:0]         rr_w  [0:NW];
	logic                  rs_w  [0:NW];
	logic                  qv_w  [0:SB];
	logic [TB-1:0]         qt_w  [0:SB];
	logic [SB+1:0]         qr_w  [0:SB];
	logic [SB-1:0]         qq_w  [0:SB];
	logic [AW-1:0]         qs_w  [0:SB];

	// centre delay line
	logic                  dvld_q [0:DLY-1];
	logic [NW-1:0]         dqx_q  [0:DLY-1];
	logic [NW-1:0]         dqy_q  [0:DLY-1];
	logic                  dnx_q  [0:DLY-1];
	logic                  dny_q  [0:DLY-1];

	// output register and skid stage
	logic                  out_valid_q;
	logic                  skid_full_q;
	logic                  res_v_q, skid_v_q;
	logic [OW-1:0]         res_x_q, res_y_q, res_r_q;
	logic [OW-1:0]         skid_x_q, skid_y_q, skid_r_q;

	logic                  end_vld;
	logic                  fin_v;
	logic [OW-1:0]         fin_x, fin_y, fin_r;

	assign en       = !skid_full_q;
	assign in_ready = en;

	// stage 1: differences, squared norms, squared side lengths
	logic signed [N:0]     dy23_c, dy31_c, dy12_c, dx32_c, dx13_c, dx21_c;
	logic [SQB-1:0]        na_c, nb_c, nc_c, sa_c, sb_c, sc_c;

	function automatic logic [SQB-1:0] sq_u(input logic [N-1:0] v);
		logic [SQB-1:0] e;
		e = SQB'(v);
		return e * e;
	endfunction

	function automatic logic [SQB-1:0] sq_s(input logic signed [N:0] v);
		logic signed [SQB:0] e;
		logic signed [SQB:0] p;
		e = (SQB + 1)'(v);
		p = e * e;
		return p[SQB-1:0];
	endfunction

	always_comb begin
		dy23_c = $signed({1'b0, by_coord}) - $signed({1'b0, cy});
		dy31_c = $signed({1'b0, cy}) - $signed({1'b0, ay});
		dy12_c = $signed({1'b0, ay}) - $signed({1'b0, by_coord});
		dx32_c = $signed({1'b0, cx}) - $signed({1'b0, bx});
		dx13_c = $signed({1'b0, ax}) - $signed({1'b0, cx});
		dx21_c = $signed({1'b0, bx}) - $signed({1'b0, ax});
		na_c   = sq_u(ax) + sq_u(ay);
		nb_c   = sq_u(bx) + sq_u(by_coord);
		nc_c   = sq_u(cx) + sq_u(cy);
		sa_c   = sq_s(dx32_c) + sq_s(dy23_c);
		sb_c   = sq_s(dx13_c) + sq_s(dy31_c);
		sc_c   = sq_s(dx21_c) + sq_s(dy12_c);
	end

	// stage 2: determinant, centre numerators, first side product
	logic signed [DB-1:0]  det_c;
	logic signed [EB-1:0]  ne_c, nf_c;

	always_comb begin
		logic signed [DB-1:0] x1e, x2e, x3e, y23e, y31e, y12e;
		logic signed [EB-1:0] ae, be, ce, ey23, ey31, ey12, ex32, ex13, ex21;
		x1e   = $signed(DB'(ax_s1));
		x2e   = $signed(DB'(bx_s1));
		x3e   = $signed(DB'(cx_s1));
		y23e  = DB'(dy23_s1);
		y31e  = DB'(dy31_s1);
		y12e  = DB'(dy12_s1);
		ae    = $signed(EB'(na_s1));
		be    = $signed(EB'(nb_s1));
		ce    = $signed(EB'(nc_s1));
		ey23  = EB'(dy23_s1);
		ey31  = EB'(dy31_s1);
		ey12  = EB'(dy12_s1);
		ex32  = EB'(dx32_s1);
		ex13  = EB'(dx13_s1);
		ex21  = EB'(dx21_s1);
		det_c = x1e * y23e + x2e * y31e + x3e * y12e;
		ne_c  = ae * ey23 + be * ey31 + ce * ey12;
		nf_c  = ae * ex32 + be * ex13 + ce * ex21;
	end

	// stage 3: magnitudes and signs for rounding, split side product
	logic [AW-1:0]         ad_c;
	logic [EB-2:0]         une_c, unf_c;

	always_comb begin
		logic [DB-1:0] dneg;
		logic [EB-1:0] eneg, fneg;
		dneg  = DB'(0) - det_s2;
		eneg  = EB'(0) - ne_s2;
		fneg  = EB'(0) - nf_s2;
		ad_c  = det_s2[DB-1] ? dneg[AW-1:0] : det_s2[AW-1:0];
		une_c = ne_s2[EB-1] ? eneg[EB-2:0] : ne_s2[EB-2:0];
		unf_c = nf_s2[EB-1] ? fneg[EB-2:0] : nf_s2[EB-2:0];
	end

	// valid flags of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= qv_w[SB];
		end
	end

	// front stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax;
			bx_s1   <= bx;
			cx_s1   <= cx;
			dy23_s1 <= dy23_c;
			dy31_s1 <= dy31_c;
			dy12_s1 <= dy12_c;
			dx32_s1 <= dx32_c;
			dx13_s1 <= dx13_c;
			dx21_s1 <= dx21_c;
			na_s1   <= na_c;
			nb_s1   <= nb_c;
			nc_s1   <= nc_c;
			sa_s1   <= sa_c;
			sb_s1   <= sb_c;
			sc_s1   <= sc_c;

			det_s2  <= det_c;
			ne_s2   <= ne_c;
			nf_s2   <= nf_c;
			pab_s2  <= PB'(sa_s1) * PB'(sb_s1);
			sc_s2   <= sc_s1;

			ad_s3   <= ad_c;
			numx_s3 <= NW'({une_c, 1'b0}) + NW'({ad_c, 1'b0});
			numy_s3 <= NW'({unf_c, 1'b0}) + NW'({ad_c, 1'b0});
			denc_s3 <= DW'({ad_c, 2'b00});
			negx_s3 <= ne_s2[EB-1] ^ det_s2[DB-1];
			negy_s3 <= nf_s2[EB-1] ^ det_s2[DB-1];
			plo_s3  <= PB'(pab_s2[L-1:0]) * PB'(sc_s2);
			phi_s3  <= PB'(pab_s2[PB-1:L]) * PB'(sc_s2);

			ad_s4   <= ad_s3;
			rad_s4  <= TB'(plo_s3) + (TB'(phi_s3) << L);

			numr_s5 <= NW'(qq_w[SB]) + NW'(qs_w[SB]);
			denr_s5 <= DW'({qs_w[SB], 1'b0});
			nz_s5   <= qs_w[SB] != AW'(0);
		end
	end

	// chain heads
	assign cvx_w[0] = vld_s3;
	assign cnx_w[0] = numx_s3;
	assign cdx_w[0] = denc_s3;
	assign crx_w[0] = DW'(0);
	assign csx_w[0] = negx_s3;
	assign cvy_w[0] = vld_s3;
	assign cny_w[0] = numy_s3;
	assign cdy_w[0] = denc_s3;
	assign cry_w[0] = DW'(0);
	assign csy_w[0] = negy_s3;
	assign qv_w[0]  = vld_s4;
	assign qt_w[0]  = rad_s4;
	assign qr_w[0]  = (SB + 2)'(0);
	assign qq_w[0]  = SB'(0);
	assign qs_w[0]  = ad_s4;
	assign rv_w[0]  = vld_s5;
	assign rn_w[0]  = numr_s5;
	assign rd_w[0]  = denr_s5;
	assign rr_w[0]  = DW'(0);
	assign rs_w[0]  = nz_s5;

	// centre and radius divider chains
	for (genvar i = 0; i < NW; i++) begin : g_div
		ccp_div_cell #(.NW(NW), .DW(DW), .SW(1)) u_cx (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(cvx_w[i]), .num_i(cnx_w[i]), .den_i(cdx_w[i]),
			.rem_i(crx_w[i]), .side_i(csx_w[i]),
			.vld_o(cvx_w[i+1]), .num_o(cnx_w[i+1]), .den_o(cdx_w[i+1]),
			.rem_o(crx_w[i+1]), .side_o(csx_w[i+1])
		);
		ccp_div_cell #(.NW(NW), .DW(DW), .SW(1)) u_cy (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(cvy_w[i]), .num_i(cny_w[i]), .den_i(cdy_w[i]),
			.rem_i(cry_w[i]), .side_i(csy_w[i]),
			.vld_o(cvy_w[i+1]), .num_o(cny_w[i+1]), .den_o(cdy_w[i+1]),
			.rem_o(cry_w[i+1]), .side_o(csy_w[i+1])
		);
		ccp_div_cell #(.NW(NW), .DW(DW), .SW(1)) u_rad (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(rv_w[i]), .num_i(rn_w[i]), .den_i(rd_w[i]),
			.rem_i(rr_w[i]), .side_i(rs_w[i]),
			.vld_o(rv_w[i+1]), .num_o(rn_w[i+1]), .den_o(rd_w[i+1]),
			.rem_o(rr_w[i+1]), .side_o(rs_w[i+1])
		);
	end

	// square-root chain on the product of squared sides
	for (genvar j = 0; j < SB; j++) begin : g_sqrt
		ccp_sqrt_cell #(.SB(SB), .SW(AW)) u_sq (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(qv_w[j]), .rad_i(qt_w[j]), .rem_i(qr_w[j]),
			.root_i(qq_w[j]), .side_i(qs_w[j]),
			.vld_o(qv_w[j+1]), .rad_o(qt_w[j+1]), .rem_o(qr_w[j+1]),
			.root_o(qq_w[j+1]), .side_o(qs_w[j+1])
		);
	end

	// delay the centre quotients to meet the radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DLY; k++) begin
				dvld_q[k] <= 1'b0;
			end
		end else if (en) begin
			dvld_q[0] <= cvx_w[NW];
			for (int k = 1; k < DLY; k++) begin
				dvld_q[k] <= dvld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dqx_q[0] <= cnx_w[NW];
			dqy_q[0] <= cny_w[NW];
			dnx_q[0] <= csx_w[NW];
			dny_q[0] <= csy_w[NW];
			for (int k = 1; k < DLY; k++) begin
				dqx_q[k] <= dqx_q[k-1];
				dqy_q[k] <= dqy_q[k-1];
				dnx_q[k] <= dnx_q[k-1];
				dny_q[k] <= dny_q[k-1];
			end
		end
	end

	assign end_vld = dvld_q[DLY-1];

	// saturate and sign the quotients, zero out collinear triples
	function automatic logic [OW-1:0] cen_sat(input logic [NW-1:0] q, input logic neg);
		logic [EW-1:0] qe;
		logic [EW-1:0] qn;
		qe = EW'(q);
		qn = EW'(0) - qe;
		if (neg) begin
			if (qe > EW'(ccp_pkg::CEN_NEG_MAG)) begin
				return OW'(EW'(0) - EW'(ccp_pkg::CEN_NEG_MAG));
			end
			return qn[OW-1:0];
		end
		if (qe > EW'(ccp_pkg::CEN_POS_MAX)) begin
			return ccp_pkg::CEN_POS_MAX[OW-1:0];
		end
		return qe[OW-1:0];
	endfunction

	always_comb begin
		logic [EW-1:0] re;
		re    = EW'(rn_w[NW]);
		fin_v = rs_w[NW];
		fin_x = fin_v ? cen_sat(dqx_q[DLY-1], dnx_q[DLY-1]) : OW'(0);
		fin_y = fin_v ? cen_sat(dqy_q[DLY-1], dny_q[DLY-1]) : OW'(0);
		if (!fin_v) begin
			fin_r = OW'(0);
		end else if (re > EW'(ccp_pkg::RAD_MAX)) begin
			fin_r = ccp_pkg::RAD_MAX[OW-1:0];
		end else begin
			fin_r = re[OW-1:0];
		end
	end

	// output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (skid_full_q) begin
				if (out_ready) begin
					skid_full_q <= 1'b0;
				end
			end else if (end_vld) begin
				if (out_valid_q && !out_ready) begin
					skid_full_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_ready) begin
				res_v_q <= skid_v_q;
				res_x_q <= skid_x_q;
				res_y_q <= skid_y_q;
				res_r_q <= skid_r_q;
			end
		end else if (end_vld) begin
			if (out_valid_q && !out_ready) begin
				skid_v_q <= fin_v;
				skid_x_q <= fin_x;
				skid_y_q <= fin_y;
				skid_r_q <= fin_r;
			end else begin
				res_v_q <= fin_v;
				res_x_q <= fin_x;
				res_y_q <= fin_y;
				res_r_q <= fin_r;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign valid_res     = res_v_q;
	assign center_x      = $signed(res_x_q);
	assign center_y      = $signed(res_y_q);
	assign circle_radius = res_r_q;

	// both centre chains carry the same items
	a_centre_align: assert property (@(posedge clk) disable iff (!arst_n)
		cvx_w[NW] == cvy_w[NW])
		else $error("centre divider chains out of step");

	// centre delay line and radius chain meet on the same item
	a_path_align: assert property (@(posedge clk) disable iff (!arst_n)
		end_vld == rv_w[NW])
		else $error("centre and radius paths out of step");

	// skid stage only fills behind a waiting result
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid stage filled without a stalled result");

	// collinear triples leave zero fields
	a_collinear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |->
		(center_x == '0 && center_y == '0 && circle_radius == '0))
		else $error("collinear result with non-zero fields");

endmodule
